/* design/sgts_pkg.sv */
// Shared constants, codes and types of the scatter-gather transfer splitter.
`default_nettype none
package sgts_pkg;

    localparam int MAX_CHUNKS = 32;
    localparam int PAGE_BITS  = 12;

    localparam int ADDR_W    = 48;
    localparam int PAGES_W   = 24;
    localparam int SLOT_W    = 5;
    localparam int CNT_W     = 6;
    localparam int MODE_W    = 2;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 1;

    localparam int CL_W    = PAGES_W + PAGE_BITS;
    localparam int NCAP    = (MAX_CHUNKS < 32) ? MAX_CHUNKS : 32;
    localparam int PTR_W   = (NCAP > 1) ? $clog2(NCAP) : 1;
    localparam int MEM_AW  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int TOTAL_W = CL_W + $clog2(NCAP + 1);
    localparam int CMP_W   = ((TOTAL_W > ADDR_W) ? TOTAL_W : ADDR_W) + 1;

    localparam int S_DATA_W  = 224;
    localparam int M_DATA_W  = 152;
    localparam int OUT_PAD_W = M_DATA_W - 3 * ADDR_W - 1;

    localparam logic FUNC_LOAD = 1'b0;

    localparam logic [MODE_W-1:0] MODE_DUAL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BAD  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_BYTES   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNKS_IN_USE = 1'b1;

    typedef enum logic [1:0] {
        K_LOAD,
        K_XFER,
        K_RANGE_ERR,
        K_MODE_ERR
    } t_sgts_kind;

    typedef enum logic [STAT_W-1:0] {
        STAT_DESC     = 2'd0,
        STAT_RANGE    = 2'd1,
        STAT_MODE     = 2'd2,
        STAT_LOAD_ACK = 2'd3
    } t_sgts_stat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_CHK,
        S_SGL,
        S_DHEAD,
        S_DLOOK,
        S_DFINAL
    } t_sgts_state;

    typedef struct packed {
        t_sgts_kind           kind;
        logic [SLOT_W-1:0]    slot;
        logic [ADDR_W-1:0]    host;
        logic [PAGES_W-1:0]   pages;
        logic [ADDR_W-1:0]    card;
        logic [ADDR_W-1:0]    off;
        logic [ADDR_W-1:0]    len;
        logic                 dir;
        logic                 dual;
    } t_sgts_req;

endpackage
`default_nettype wire

/* design/sgts_front.sv */
// Front end: configuration registers, input unpacking and request classification.
`default_nettype none
module sgts_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sgts_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sgts_pkg::ADDR_W-1:0]     i_cfg_wdata,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [sgts_pkg::S_DATA_W-1:0]   i_s_axis_tdata,
    input  logic                            i_s_axis_tuser,
    input  logic                            i_q_full,
    output logic                            o_q_push,
    output sgts_pkg::t_sgts_req             o_q_data,
    output logic [sgts_pkg::CNT_W-1:0]      o_chunks_in_use
);
    import sgts_pkg::*;

    logic [ADDR_W-1:0] r_range_bytes;
    logic [CNT_W-1:0]  r_chunks_in_use;
    logic [MODE_W-1:0] mode;
    logic              range_over;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_bytes   <= '0;
            r_chunks_in_use <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RANGE_BYTES:   r_range_bytes   <= i_cfg_wdata;
                REG_CHUNKS_IN_USE: r_chunks_in_use <= i_cfg_wdata[CNT_W-1:0];
            endcase
        end
    end

    assign mode = i_s_axis_tdata[223:222];
    assign range_over = ({1'b0, i_s_axis_tdata[172:125]} + {1'b0, i_s_axis_tdata[220:173]})
                        > {1'b0, r_range_bytes};

    always_comb begin
        o_q_data.slot  = i_s_axis_tdata[4:0];
        o_q_data.host  = i_s_axis_tdata[52:5];
        o_q_data.pages = i_s_axis_tdata[76:53];
        o_q_data.card  = i_s_axis_tdata[124:77];
        o_q_data.off   = i_s_axis_tdata[172:125];
        o_q_data.len   = i_s_axis_tdata[220:173];
        o_q_data.dir   = i_s_axis_tdata[221];
        o_q_data.dual  = (mode == MODE_DUAL);
        if (i_s_axis_tuser == FUNC_LOAD) begin
            o_q_data.kind = K_LOAD;
        end else if (range_over) begin
            o_q_data.kind = K_RANGE_ERR;
        end else if (mode == MODE_BAD) begin
            o_q_data.kind = K_MODE_ERR;
        end else begin
            o_q_data.kind = K_XFER;
        end
    end

    assign o_s_axis_tready = !i_q_full;
    assign o_q_push        = i_s_axis_tvalid && !i_q_full;
    assign o_chunks_in_use = r_chunks_in_use;

endmodule
`default_nettype wire

/* design/sgts_queue.sv */
// Two-entry request queue between the front end and the descriptor engine.
`default_nettype none
module sgts_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  sgts_pkg::t_sgts_req  i_data,
    output logic                 o_full,
    output logic                 o_valid,
    output sgts_pkg::t_sgts_req  o_data,
    input  logic                 i_pop
);
    import sgts_pkg::*;

    t_sgts_req  r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_pop;

    assign do_pop  = i_pop && (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

/* design/sgts_back.sv */
// Descriptor engine: chunk table, table walk and registered descriptor output.
`default_nettype none
module sgts_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sgts_pkg::t_sgts_req            i_req,
    input  logic                           i_req_valid,
    output logic                           o_req_pop,
    input  logic [sgts_pkg::CNT_W-1:0]     i_chunks_in_use,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [sgts_pkg::M_DATA_W-1:0]  o_m_axis_tdata,
    output logic [sgts_pkg::STAT_W-1:0]    o_m_axis_tuser,
    output logic                           o_m_axis_tlast
);
    import sgts_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic [ADDR_W-1:0] len;
        logic              ch;
        t_sgts_stat        stat;
        logic              last;
    } t_out;

    function automatic t_out mk_desc(input logic [ADDR_W-1:0] host,
                                     input logic [ADDR_W-1:0] card,
                                     input logic [ADDR_W-1:0] len,
                                     input logic ch, input logic last, input logic dir);
        t_out o;
        o.src  = dir ? host : card;
        o.dst  = dir ? card : host;
        o.len  = len;
        o.ch   = ch;
        o.stat = STAT_DESC;
        o.last = last;
        return o;
    endfunction

    function automatic t_out mk_stat(input t_sgts_stat st);
        t_out o;
        o      = '0;
        o.stat = st;
        o.last = 1'b1;
        return o;
    endfunction

    logic [ADDR_W-1:0]  m_host  [MAX_CHUNKS];
    logic [PAGES_W-1:0] m_pages [MAX_CHUNKS];
    logic [ADDR_W-1:0]  r_rd_host;
    logic [PAGES_W-1:0] r_rd_pages;
    logic               mem_we;

    t_sgts_state        r_state, n_state;
    logic [PTR_W-1:0]   r_ptr, n_ptr;
    logic [PTR_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [TOTAL_W-1:0] r_cum, n_cum;
    logic               r_found, n_found;
    logic [CL_W-1:0]    r_co, n_co;
    logic [CL_W-1:0]    r_cr, n_cr;
    logic [ADDR_W-1:0]  r_base, n_base;
    logic [ADDR_W-1:0]  r_card, n_card;
    logic [ADDR_W-1:0]  r_off, n_off;
    logic [ADDR_W-1:0]  r_rem, n_rem;
    logic               r_dir, n_dir;
    logic               r_dual, n_dual;
    logic               r_out_valid;
    t_out               r_out;
    logic               emit;
    t_out               e_out;

    logic [CL_W-1:0]    sz;
    logic [TOTAL_W-1:0] cum_nx;
    logic [CNT_W-1:0]   ptr_p1;
    logic [CNT_W-1:0]   n_cap;
    logic [CL_W-1:0]    cr_s;
    logic               out_free;
    logic               at_tail;
    logic               found_here;
    logic               range_bad;
    logic               sgl_end;
    logic               head_fits;
    logic               look_more;

    assign sz         = {r_rd_pages, {PAGE_BITS{1'b0}}};
    assign cum_nx     = r_cum + TOTAL_W'(sz);
    assign ptr_p1     = CNT_W'(r_ptr) + CNT_W'(1);
    assign n_cap      = (i_chunks_in_use > CNT_W'(NCAP)) ? CNT_W'(NCAP) : i_chunks_in_use;
    assign cr_s       = sz - r_co;
    assign out_free   = !r_out_valid || i_m_axis_tready;
    assign at_tail    = (ptr_p1 >= r_n);
    assign found_here = !r_found && (CMP_W'(cum_nx) > CMP_W'(r_off));
    assign range_bad  = !r_found || ((CMP_W'(r_off) + CMP_W'(r_rem)) > CMP_W'(r_cum));
    assign sgl_end    = (CMP_W'(cr_s) >= CMP_W'(r_rem)) || at_tail;
    assign head_fits  = (CMP_W'(r_co) + CMP_W'(r_rem)) <= CMP_W'(sz);
    assign look_more  = (ptr_p1 < r_n) && ((CMP_W'(r_cr) + CMP_W'(sz)) < CMP_W'(r_rem));

    assign mem_we = (r_state == S_IDLE) && i_req_valid && out_free && (i_req.kind == K_LOAD)
                    && (int'(i_req.slot) < MAX_CHUNKS);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            m_host[MEM_AW'(i_req.slot)]  <= i_req.host;
            m_pages[MEM_AW'(i_req.slot)] <= i_req.pages;
        end
        r_rd_host  <= m_host[MEM_AW'(n_ptr)];
        r_rd_pages <= m_pages[MEM_AW'(n_ptr)];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid && out_free && (i_req.kind == K_XFER) && (n_cap != '0)) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (at_tail) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (range_bad) begin
                    if (out_free) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = r_dual ? S_DHEAD : S_SGL;
                end
            end
            S_SGL: begin
                if (out_free && sgl_end) begin
                    n_state = S_IDLE;
                end
            end
            S_DHEAD: begin
                if (head_fits) begin
                    if (out_free) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_DLOOK;
                end
            end
            S_DLOOK: begin
                if (out_free && !look_more) begin
                    n_state = S_DFINAL;
                end
            end
            S_DFINAL: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_ptr     = r_ptr;
        n_idx     = r_idx;
        n_n       = r_n;
        n_cum     = r_cum;
        n_found   = r_found;
        n_co      = r_co;
        n_cr      = r_cr;
        n_base    = r_base;
        n_card    = r_card;
        n_off     = r_off;
        n_rem     = r_rem;
        n_dir     = r_dir;
        n_dual    = r_dual;
        o_req_pop = 1'b0;
        emit      = 1'b0;
        e_out     = mk_stat(STAT_RANGE);
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid && out_free) begin
                    o_req_pop = 1'b1;
                    unique case (i_req.kind)
                        K_LOAD: begin
                            emit  = 1'b1;
                            e_out = mk_stat(STAT_LOAD_ACK);
                        end
                        K_RANGE_ERR: begin
                            emit  = 1'b1;
                            e_out = mk_stat(STAT_RANGE);
                        end
                        K_MODE_ERR: begin
                            emit  = 1'b1;
                            e_out = mk_stat(STAT_MODE);
                        end
                        K_XFER: begin
                            n_n     = n_cap;
                            n_ptr   = '0;
                            n_cum   = '0;
                            n_found = 1'b0;
                            n_off   = i_req.off;
                            n_rem   = i_req.len;
                            n_card  = i_req.card;
                            n_dir   = i_req.dir;
                            n_dual  = i_req.dual;
                            if (n_cap == '0) begin
                                emit  = 1'b1;
                                e_out = mk_stat(STAT_RANGE);
                            end
                        end
                    endcase
                end
            end
            S_SUM: begin
                n_cum = cum_nx;
                if (found_here) begin
                    n_found = 1'b1;
                    n_idx   = r_ptr;
                    n_co    = CL_W'(r_off - ADDR_W'(r_cum));
                end
                if (!at_tail) begin
                    n_ptr = r_ptr + PTR_W'(1);
                end
            end
            S_CHK: begin
                if (range_bad) begin
                    emit  = out_free;
                    e_out = mk_stat(STAT_RANGE);
                end else begin
                    n_ptr = r_idx;
                end
            end
            S_SGL: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (sgl_end) begin
                        e_out = mk_desc(r_rd_host + ADDR_W'(r_co), r_card, r_rem,
                                        1'b0, 1'b1, r_dir);
                    end else begin
                        e_out  = mk_desc(r_rd_host + ADDR_W'(r_co), r_card, ADDR_W'(cr_s),
                                         1'b0, 1'b0, r_dir);
                        n_card = r_card + ADDR_W'(cr_s);
                        n_rem  = r_rem - ADDR_W'(cr_s);
                        n_co   = '0;
                        n_ptr  = r_ptr + PTR_W'(1);
                    end
                end
            end
            S_DHEAD: begin
                if (head_fits) begin
                    emit  = out_free;
                    e_out = mk_desc(r_rd_host + ADDR_W'(r_co), r_card, r_rem,
                                    1'b0, 1'b1, r_dir);
                end else begin
                    n_cr   = cr_s;
                    n_base = r_rd_host;
                    n_ptr  = r_ptr + PTR_W'(1);
                end
            end
            S_DLOOK: begin
                // r_ptr is one past the chunk being sent; inner chunks at even
                // positions go on the second channel
                if (out_free) begin
                    emit   = 1'b1;
                    n_card = r_card + ADDR_W'(r_cr);
                    n_rem  = r_rem - ADDR_W'(r_cr);
                    if (look_more) begin
                        e_out  = mk_desc(r_base + ADDR_W'(r_co), r_card, ADDR_W'(r_cr),
                                         r_ptr[0], 1'b0, r_dir);
                        n_co   = '0;
                        n_cr   = sz;
                        n_base = r_rd_host;
                        n_ptr  = r_ptr + PTR_W'(1);
                    end else begin
                        e_out = mk_desc(r_base + ADDR_W'(r_co), r_card, ADDR_W'(r_cr),
                                        1'b0, 1'b0, r_dir);
                    end
                end
            end
            S_DFINAL: begin
                emit  = out_free;
                e_out = mk_desc(r_rd_host, r_card, r_rem, 1'b1, 1'b1, r_dir);
            end
            default: emit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr   <= n_ptr;
        r_idx   <= n_idx;
        r_n     <= n_n;
        r_cum   <= n_cum;
        r_found <= n_found;
        r_co    <= n_co;
        r_cr    <= n_cr;
        r_base  <= n_base;
        r_card  <= n_card;
        r_off   <= n_off;
        r_rem   <= n_rem;
        r_dir   <= n_dir;
        r_dual  <= n_dual;
        if (emit) begin
            r_out <= e_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out.ch, r_out.len, r_out.dst, r_out.src};
    assign o_m_axis_tuser  = r_out.stat;
    assign o_m_axis_tlast  = r_out.last;

endmodule
`default_nettype wire

/* design/scatter_gather_transfer_splitter_unit.sv */
// Top level of the scatter-gather transfer splitter.
// Load items write one chunk table slot and answer with one acknowledge; a
// request that fails the range or mode check answers with one status result.
// The descriptor engine answers these from its idle state. A valid transfer
// first walks the n valid table entries (n = chunks_in_use, capped at 32) to
// build the total size and find the starting chunk, one entry per cycle, then
// checks the range against that total and emits the descriptors in order; in
// dual mode a first chunk that does not hold the whole transfer takes an extra
// state before its descriptor. The walk reads the chunk table through its
// single read port. A two-entry queue lets the input side keep taking items
// while the engine is busy, and the output register holds a finished result
// until the downstream side takes it.
`default_nettype none
module scatter_gather_transfer_splitter_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sgts_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sgts_pkg::ADDR_W-1:0]     i_cfg_wdata,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // entry_index, entry_host_addr, entry_pages, card_addr, host_offset,
    // transfer_length, direction, mode
    input  logic [sgts_pkg::S_DATA_W-1:0]   i_s_axis_tdata,
    // func
    input  logic                            i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // src_addr, dst_addr, desc_length, channel, zero pad
    output logic [sgts_pkg::M_DATA_W-1:0]   o_m_axis_tdata,
    // status
    output logic [sgts_pkg::STAT_W-1:0]     o_m_axis_tuser,
    output logic                            o_m_axis_tlast
);
    import sgts_pkg::*;

    t_sgts_req        push_data;
    t_sgts_req        head_data;
    logic             push;
    logic             q_full;
    logic             head_valid;
    logic             pop;
    logic [CNT_W-1:0] chunks_in_use;

    sgts_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_q_full        (q_full),
        .o_q_push        (push),
        .o_q_data        (push_data),
        .o_chunks_in_use (chunks_in_use)
    );

    sgts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (q_full),
        .o_valid (head_valid),
        .o_data  (head_data),
        .i_pop   (pop)
    );

    sgts_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (head_data),
        .i_req_valid     (head_valid),
        .o_req_pop       (pop),
        .i_chunks_in_use (chunks_in_use),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule
`default_nettype wire

/* design/sgts_checker.sv */
// Port-level checks for the transfer splitter and their bind to the top level.
`default_nettype none
module sgts_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [sgts_pkg::M_DATA_W-1:0]   o_m_axis_tdata,
    input logic [sgts_pkg::STAT_W-1:0]     o_m_axis_tuser,
    input logic                            o_m_axis_tlast
);
    import sgts_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
             && $stable(o_m_axis_tlast)))
        else $error("output transfer changed while stalled");

    a_stat_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != STAT_DESC)) |-> o_m_axis_tlast)
        else $error("status result without last");

    a_stat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != STAT_DESC)) |-> (o_m_axis_tdata == '0))
        else $error("status result with nonzero payload");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind scatter_gather_transfer_splitter_unit sgts_checker u_sgts_checker (.*);
`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the scatter-gather transfer splitter: chunk table loads and split transfers.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sgts_pkg::*;

    localparam logic              FUNC_XFER      = 1'b1;
    localparam logic [MODE_W-1:0] MODE_SINGLE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_AUTO      = 2'd2;
    localparam logic [63:0]       PAGE_BYTES     = 64'd1 << PAGE_BITS;
    localparam logic [ADDR_W-1:0] ADDR_MAX       = '1;
    localparam int                WATCHDOG_LIMIT = 2000;
    localparam int                DRAIN_CYCLES   = 80;

    typedef struct packed {
        logic                func;
        logic [SLOT_W-1:0]   slot;
        logic [ADDR_W-1:0]   host;
        logic [PAGES_W-1:0]  pages;
        logic [ADDR_W-1:0]   card;
        logic [ADDR_W-1:0]   off;
        logic [ADDR_W-1:0]   len;
        logic                dir;
        logic [MODE_W-1:0]   mode;
    } sg_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic [ADDR_W-1:0] len;
        logic              ch;
        t_sgts_stat        stat;
        logic              last;
    } sg_desc_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [ADDR_W-1:0]    cfg_wdata = '0;
    logic                 drv_valid = 1'b0;
    logic [S_DATA_W-1:0]  drv_data  = '0;
    logic                 drv_func  = 1'b0;
    logic                 rcv_ready = 1'b0;
    logic                 s_ready;
    logic                 m_valid;
    logic [M_DATA_W-1:0]  m_data;
    logic [STAT_W-1:0]    m_stat;
    logic                 m_last;

    scatter_gather_transfer_splitter_unit u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (drv_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (drv_data),
        .i_s_axis_tuser  (drv_func),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (rcv_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_stat),
        .o_m_axis_tlast  (m_last)
    );

    logic [ADDR_W-1:0]  tbl_host  [MAX_CHUNKS];
    logic [PAGES_W-1:0] tbl_pages [MAX_CHUNKS];
    logic [PAGES_W-1:0] gen_pages [MAX_CHUNKS];
    logic [ADDR_W-1:0]  cfg_range  = '0;
    logic [CNT_W-1:0]   cfg_chunks = '0;

    sg_item_t pend_items_q[$];
    sg_desc_t desc_expect_q[$];
    sg_desc_t desc_buf [MAX_CHUNKS];
    sg_item_t drv_item;

    int n_desc;
    int items_in_flight = 0;
    int err_cnt         = 0;
    int idle_cycles     = 0;
    int drv_gap         = 0;
    int rcv_stall       = 0;
    bit quiet           = 1'b0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------- descriptor prediction ----------------
    function automatic logic [63:0] chunk_bytes(input int idx);
        if (idx >= MAX_CHUNKS) return 64'd0;
        return {40'd0, tbl_pages[idx]} << PAGE_BITS;
    endfunction

    task automatic add_desc(input logic [63:0] host, input logic [63:0] card,
                            input logic [63:0] len, input logic ch, input logic dir);
        sg_desc_t d;
        d.src  = dir ? host[ADDR_W-1:0] : card[ADDR_W-1:0];
        d.dst  = dir ? card[ADDR_W-1:0] : host[ADDR_W-1:0];
        d.len  = len[ADDR_W-1:0];
        d.ch   = ch;
        d.stat = STAT_DESC;
        d.last = 1'b0;
        desc_buf[n_desc] = d;
        n_desc++;
    endtask

    task automatic expect_status(input t_sgts_stat st);
        sg_desc_t d;
        d      = '0;
        d.stat = st;
        d.last = 1'b1;
        desc_expect_q.push_back(d);
    endtask

    task automatic split_request(input sg_item_t it);
        logic [63:0] off, len, card, total, co, rem, cr, bytes;
        int n, idx, i;
        n_desc = 0;
        if (it.func == FUNC_LOAD) begin
            tbl_host[it.slot]  = it.host;
            tbl_pages[it.slot] = it.pages;
            expect_status(STAT_LOAD_ACK);
            return;
        end
        off  = {16'd0, it.off};
        len  = {16'd0, it.len};
        card = {16'd0, it.card};
        if (off + len > {16'd0, cfg_range}) begin
            expect_status(STAT_RANGE);
            return;
        end
        if (it.mode == MODE_BAD) begin
            expect_status(STAT_MODE);
            return;
        end
        n = (cfg_chunks > NCAP) ? NCAP : int'(cfg_chunks);
        total = 64'd0;
        for (i = 0; i < n; i++) total += chunk_bytes(i);
        if (off >= total || off + len > total) begin
            expect_status(STAT_RANGE);
            return;
        end
        co  = off;
        idx = 0;
        for (i = 0; i < n; i++) begin
            bytes = chunk_bytes(i);
            if (bytes > co) begin
                idx = i;
                break;
            end
            co -= bytes;
        end
        rem = len;
        if (it.mode != MODE_DUAL) begin
            i  = idx;
            cr = chunk_bytes(i) - co;
            while (cr < rem && i + 1 < n) begin
                add_desc({16'd0, tbl_host[i]} + co, card, cr, 1'b0, it.dir);
                card += cr;
                rem  -= cr;
                co    = 64'd0;
                i++;
                cr = chunk_bytes(i);
            end
            add_desc({16'd0, tbl_host[i]} + co, card, rem, 1'b0, it.dir);
        end else if (co + rem <= chunk_bytes(idx)) begin
            add_desc({16'd0, tbl_host[idx]} + co, card, rem, 1'b0, it.dir);
        end else begin
            cr = chunk_bytes(idx) - co;
            i  = idx;
            // inner chunks alternate channels, the closing pair goes 0 then 1
            while (i + 2 < n && cr + chunk_bytes(i + 1) < rem) begin
                add_desc({16'd0, tbl_host[i]} + co, card, cr, (i % 2 == 0), it.dir);
                card += cr;
                rem  -= cr;
                co    = 64'd0;
                cr    = chunk_bytes(i + 1);
                i++;
            end
            add_desc({16'd0, tbl_host[i]} + co, card, cr, 1'b0, it.dir);
            card += cr;
            rem  -= cr;
            add_desc({16'd0, tbl_host[i + 1]}, card, rem, 1'b1, it.dir);
        end
        desc_buf[n_desc - 1].last = 1'b1;
        for (i = 0; i < n_desc; i++) desc_expect_q.push_back(desc_buf[i]);
    endtask

    // ---------------- stimulus helpers ----------------
    function automatic logic [ADDR_W-1:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[ADDR_W-1:0];
    endfunction

    function automatic logic [PAGES_W-1:0] rand_pages();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return r[PAGES_W-1:0];
            default: return PAGES_W'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [63:0] gen_span(input int k);
        logic [63:0] s;
        s = 64'd0;
        for (int j = 0; j < k; j++) s += {40'd0, gen_pages[j]} << PAGE_BITS;
        return s;
    endfunction

    function automatic sg_item_t load_item(input logic [SLOT_W-1:0] slot,
                                           input logic [ADDR_W-1:0] host,
                                           input logic [PAGES_W-1:0] pages);
        sg_item_t it;
        it.func  = FUNC_LOAD;
        it.slot  = slot;
        it.host  = host;
        it.pages = pages;
        it.card  = rand48();
        it.off   = rand48();
        it.len   = rand48();
        it.dir   = 1'($urandom_range(0, 1));
        it.mode  = MODE_W'($urandom_range(0, 3));
        return it;
    endfunction

    function automatic sg_item_t xfer_item(input logic [ADDR_W-1:0] card,
                                           input logic [63:0] off, input logic [63:0] len,
                                           input logic dir, input logic [MODE_W-1:0] mode);
        sg_item_t it;
        logic [31:0] r;
        r        = $urandom;
        it.func  = FUNC_XFER;
        it.slot  = SLOT_W'($urandom_range(0, MAX_CHUNKS - 1));
        it.host  = rand48();
        it.pages = r[PAGES_W-1:0];
        it.card  = card;
        it.off   = off[ADDR_W-1:0];
        it.len   = len[ADDR_W-1:0];
        it.dir   = dir;
        it.mode  = mode;
        return it;
    endfunction

    task automatic send(input sg_item_t it);
        if (it.func == FUNC_LOAD) gen_pages[it.slot] = it.pages;
        pend_items_q.push_back(it);
        items_in_flight++;
    endtask

    task automatic send_random();
        logic [63:0] total, off, len, r;
        logic [MODE_W-1:0] mode;
        int n;
        if ($urandom_range(0, 5) == 0) begin
            send(load_item(SLOT_W'($urandom_range(0, MAX_CHUNKS - 1)), rand48(),
                           rand_pages()));
            return;
        end
        n     = (cfg_chunks > NCAP) ? NCAP : int'(cfg_chunks);
        total = gen_span(n);
        r     = {$urandom, $urandom};
        if (total == 0 || $urandom_range(0, 15) == 0) off = {16'd0, rand48()};
        else if ($urandom_range(0, 15) == 0) off = total;
        else off = r % total;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       len = 64'd0;
            1:       len = {16'd0, rand48()};
            2, 3:    len = 64'($urandom_range(1, 32'(2 * PAGE_BYTES)));
            default: len = (off < total) ? r % (total - off + 64'd1)
                                         : 64'($urandom_range(0, 100));
        endcase
        mode = ($urandom_range(0, 15) == 0) ? MODE_BAD : MODE_W'($urandom_range(0, 2));
        send(xfer_item(rand48(), off, len, 1'($urandom_range(0, 1)), mode));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        if (idx == REG_RANGE_BYTES) cfg_range = val;
        else cfg_chunks = val[CNT_W-1:0];
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_config();
        logic [CNT_W-1:0] cnt;
        logic [63:0] total;
        case ($urandom_range(0, 9))
            0:       cnt = '0;
            1:       cnt = CNT_W'(NCAP);
            2:       cnt = CNT_W'($urandom_range(33, 63));
            3:       cnt = CNT_W'(1);
            default: cnt = CNT_W'($urandom_range(2, 32));
        endcase
        write_reg(REG_CHUNKS_IN_USE, {{(ADDR_W - CNT_W){1'b0}}, cnt});
        total = gen_span((cnt > NCAP) ? NCAP : int'(cnt));
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: write_reg(REG_RANGE_BYTES, ADDR_MAX);
            5, 6:          write_reg(REG_RANGE_BYTES, total[ADDR_W-1:0]);
            7:             write_reg(REG_RANGE_BYTES, rand48());
            8:             write_reg(REG_RANGE_BYTES, total[ADDR_W:1]);
            default:       write_reg(REG_RANGE_BYTES, '0);
        endcase
    endtask

    task automatic wait_idle();
        do @(posedge clk); while (items_in_flight != 0 || desc_expect_q.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    // ---------------- driver ----------------
    always @(posedge clk) begin
        if (drv_valid && s_ready) begin
            split_request(drv_item);
            items_in_flight--;
        end
        if (!drv_valid || s_ready) begin
            if (drv_gap > 0) begin
                drv_gap--;
                drv_valid <= 1'b0;
            end else if (!quiet && pend_items_q.size() != 0 && $urandom_range(0, 7) == 0) begin
                drv_gap = $urandom_range(0, 5);
                drv_valid <= 1'b0;
            end else if (pend_items_q.size() != 0) begin
                drv_item = pend_items_q.pop_front();
                drv_data <= {drv_item.mode, drv_item.dir, drv_item.len, drv_item.off,
                             drv_item.card, drv_item.pages, drv_item.host, drv_item.slot};
                drv_func  <= drv_item.func;
                drv_valid <= 1'b1;
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // ---------------- monitor and checker ----------------
    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge clk) begin
        sg_desc_t got, want;
        if (rst_n && m_valid && rcv_ready) begin
            got.src  = m_data[ADDR_W-1:0];
            got.dst  = m_data[2*ADDR_W-1:ADDR_W];
            got.len  = m_data[3*ADDR_W-1:2*ADDR_W];
            got.ch   = m_data[3*ADDR_W];
            got.stat = t_sgts_stat'(m_stat);
            got.last = m_last;
            if (desc_expect_q.size() == 0) begin
                $display("%0t: transfer with nothing expected, expected none, actual %h",
                         $time, got);
                err_cnt++;
            end else begin
                want = desc_expect_q.pop_front();
                check_field("src_addr", 64'(want.src), 64'(got.src));
                check_field("dst_addr", 64'(want.dst), 64'(got.dst));
                check_field("desc_length", 64'(want.len), 64'(got.len));
                check_field("channel", 64'(want.ch), 64'(got.ch));
                check_field("status", 64'(want.stat), 64'(got.stat));
                check_field("last", 64'(want.last), 64'(got.last));
            end
        end
        if (rcv_stall > 0) begin
            rcv_stall--;
            rcv_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rcv_stall = $urandom_range(0, 5);
            rcv_ready <= 1'b0;
        end else begin
            rcv_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (drv_valid && s_ready) || (m_valid && rcv_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------- test sequence ----------------
    initial begin
        int s, ph, k;
        logic [63:0] span8, span32, span30;
        for (s = 0; s < MAX_CHUNKS; s++) gen_pages[s] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole table before any transfer can read it
        send(load_item(SLOT_W'(0), 48'hFFFF_FFFF_FF00, PAGES_W'(1)));
        send(load_item(SLOT_W'(1), '0, PAGES_W'(2)));
        send(load_item(SLOT_W'(2), rand48(), '0));
        send(load_item(SLOT_W'(3), rand48(), PAGES_W'(3)));
        for (s = 4; s < MAX_CHUNKS - 1; s++) begin
            send(load_item(SLOT_W'(s), rand48(), PAGES_W'($urandom_range(1, 4))));
        end
        send(load_item(SLOT_W'(MAX_CHUNKS - 1), ADDR_MAX, '1));
        send(xfer_item(rand48(), 64'd0, 64'd1, 1'b0, MODE_SINGLE));
        send(xfer_item(rand48(), 64'd0, 64'd0, 1'b1, MODE_DUAL));
        wait_idle();

        write_reg(REG_RANGE_BYTES, ADDR_MAX);
        write_reg(REG_CHUNKS_IN_USE, ADDR_W'(8));
        span8 = gen_span(8);
        send(xfer_item(rand48(), {16'd0, ADDR_MAX}, {16'd0, ADDR_MAX}, 1'b0, MODE_BAD));
        send(xfer_item(rand48(), 64'd0, 64'd10, 1'b0, MODE_BAD));
        send(xfer_item(rand48(), 64'd5, 64'd0, 1'b1, MODE_SINGLE));
        send(xfer_item(rand48(), 64'h800, span8 - 64'h800, 1'b0, MODE_SINGLE));
        send(xfer_item(48'hFFFF_FFFF_F000, 64'h800, span8 - 64'h800, 1'b1, MODE_AUTO));
        send(xfer_item(ADDR_MAX, 64'd0, span8, 1'b0, MODE_DUAL));
        send(xfer_item(rand48(), PAGE_BYTES + 64'd16, 64'd100, 1'b1, MODE_DUAL));
        send(xfer_item(rand48(), PAGE_BYTES, 64'd3 * PAGE_BYTES, 1'b0, MODE_DUAL));
        send(xfer_item(rand48(), span8, 64'd0, 1'b0, MODE_SINGLE));
        send(xfer_item(rand48(), 64'd0, span8 + 64'd1, 1'b1, MODE_AUTO));
        send(xfer_item(rand48(), gen_span(3) + 64'd7, 64'd1, 1'b0, MODE_SINGLE));
        send(load_item(SLOT_W'(MAX_CHUNKS - 1), ADDR_MAX, '1));
        send(load_item(SLOT_W'(0), 48'hFFFF_FFFF_FF00, PAGES_W'(1)));
        wait_idle();

        write_reg(REG_RANGE_BYTES, span8[ADDR_W-1:0] - ADDR_W'(1));
        send(xfer_item(rand48(), 64'd0, span8, 1'b0, MODE_SINGLE));
        send(xfer_item(rand48(), 64'd1, span8 - 64'd2, 1'b1, MODE_DUAL));
        wait_idle();

        // count above the table size saturates
        write_reg(REG_CHUNKS_IN_USE, ADDR_W'(40));
        write_reg(REG_RANGE_BYTES, ADDR_MAX);
        span30 = gen_span(30);
        span32 = gen_span(32);
        send(xfer_item(rand48(), span30, span32 - span30, 1'b0, MODE_DUAL));
        send(xfer_item(rand48(), 64'd0, span32, 1'b1, MODE_SINGLE));
        send(xfer_item(rand48(), 64'd0, span32, 1'b0, MODE_DUAL));
        send(xfer_item(rand48(), span32 - 64'd1, 64'd1, 1'b1, MODE_AUTO));
        wait_idle();

        for (ph = 0; ph < 6; ph++) begin
            random_config();
            if (ph == 5) quiet = 1'b1;
            for (k = 0; k < 45; k++) send_random();
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0 && desc_expect_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
